FILE: sv/gdo_pkg.sv
// Package for the Gregorian date offset unit: widths, status codes, sequencer states,
// calendar tables and small calendar helper functions.
// No dependencies.
package gdo_pkg;

    localparam int unsigned MAX_YEAR_DEF    = 9999;
    localparam int unsigned OFFSET_BITS_DEF = 16;
    localparam int unsigned DN_W            = 26;
    localparam int unsigned YEAR_W          = 16;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_DATE = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam logic [8:0] CUM_DAYS [13] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    localparam logic [DN_W-1:0] DIV_YEARS [4] = '{
        DN_W'(400), DN_W'(100), DN_W'(4), DN_W'(1)
    };

    localparam logic [DN_W-1:0] DIV_DAYS [4] = '{
        DN_W'(146097), DN_W'(36524), DN_W'(1461), DN_W'(365)
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE,
        S_DSUB,
        S_DADD,
        S_CHECK,
        S_DOY,
        S_OFF,
        S_LIM,
        S_WALK,
        S_BFIX,
        S_FIN
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        status;
        logic [4:0]        day;
        logic [3:0]        month;
        logic [YEAR_W-1:0] year;
        logic [DN_W-1:0]   dn;
    } result_t;

    function automatic logic is_leap(input logic [1:0] y_low, input logic [6:0] c100,
                                     input logic [8:0] c400);
        return (y_low == 2'd0) && ((c100 != 7'd0) || (c400 == 9'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        if (m inside {4'd4, 4'd6, 4'd9, 4'd11})
        begin
            len = 5'd30;
        end
        else if (m == 4'd2)
        begin
            len = leap ? 5'd29 : 5'd28;
        end
        return len;
    endfunction

    function automatic logic [2:0] mod7(input logic [DN_W-1:0] v);
        logic [DN_W+2:0] ext;
        logic [6:0]      s1;
        logic [3:0]      s2;
        logic [3:0]      s3;
        logic [2:0]      s4;
        ext = {3'b000, v};
        s1  = '0;
        for (int i = 0; i < DN_W; i += 3)
        begin
            s1 = s1 + 7'(ext[i +: 3]);
        end
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]) + 4'(s1[6]);
        s3 = 4'(s2[2:0]) + 4'(s2[3]);
        s4 = s3[2:0] + 3'(s3[3]);
        return (s4 == 3'd7) ? 3'd0 : s4;
    endfunction

endpackage

FILE: sv/gregorian_date_offset_unit.sv
// Run time depends on the year (through the day-count loop) and on the offset, which is walked
// month by month: a boundary walked forward passes through S_WALK, one walked back S_WALK and S_BFIX.
// One transaction at a time: busy stays high from acceptance and falls as done is shown.
// Asynchronous active-low reset returns the sequencer to idle and clears done.
// Depends on gdo_pkg and gdo_core.
module gregorian_date_offset_unit #(
    parameter int unsigned MAX_YEAR    = gdo_pkg::MAX_YEAR_DEF,
    parameter int unsigned OFFSET_BITS = gdo_pkg::OFFSET_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   mode,
    input  logic [4:0]             in_day,
    input  logic [3:0]             in_month,
    input  logic [13:0]            in_year,
    input  logic [OFFSET_BITS-1:0] offset_days,
    output logic                   done,
    output logic [4:0]             out_day,
    output logic [3:0]             out_month,
    output logic [13:0]            out_year,
    output logic [21:0]            day_number,
    output logic [2:0]             weekday,
    output logic [1:0]             status
);
    import gdo_pkg::*;

    result_t res;

    logic        done_reg, done_next;
    logic [4:0]  day_reg, day_next;
    logic [3:0]  month_reg, month_next;
    logic [13:0] year_reg, year_next;
    logic [21:0] dn_reg, dn_next;
    logic [2:0]  wday_reg, wday_next;
    logic [1:0]  status_reg, status_next;

    gdo_core #(
        .MAX_YEAR    (MAX_YEAR),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .mode        (mode),
        .in_day      (in_day),
        .in_month    (in_month),
        .in_year     (in_year),
        .offset_days (offset_days),
        .busy        (busy),
        .result      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg    <= day_next;
        month_reg  <= month_next;
        year_reg   <= year_next;
        dn_reg     <= dn_next;
        wday_reg   <= wday_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        done_next   = res.valid;
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        dn_next     = dn_reg;
        wday_next   = wday_reg;
        status_next = status_reg;
        if (res.valid)
        begin
            status_next = res.status;
            if (res.status == ST_OK)
            begin
                day_next   = res.day;
                month_next = res.month;
                year_next  = res.year[13:0];
                dn_next    = res.dn[21:0];
                wday_next  = mod7(res.dn) + 3'd1;
            end
            else
            begin
                day_next   = 5'd1;
                month_next = 4'd1;
                year_next  = 14'd1;
                dn_next    = '0;
                wday_next  = 3'd1;
            end
        end
    end

    assign done       = done_reg;
    assign out_day    = day_reg;
    assign out_month  = month_reg;
    assign out_year   = year_reg;
    assign day_number = dn_reg;
    assign weekday    = wday_reg;
    assign status     = status_reg;

endmodule

FILE: sv/gdo_alu.sv
// Shared add/subtract unit of the date offset sequencer, with borrow output.
// Depends on gdo_pkg for the datapath width.
module gdo_alu (
    input  logic [gdo_pkg::DN_W-1:0] a,
    input  logic [gdo_pkg::DN_W-1:0] b,
    input  logic                     sub,
    output logic [gdo_pkg::DN_W-1:0] res,
    output logic                     borrow
);
    import gdo_pkg::*;

    logic [DN_W:0] full;

    always_comb
    begin
        if (sub)
        begin
            full = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            full = {1'b0, a} + {1'b0, b};
        end
    end

    assign res    = full[DN_W-1:0];
    assign borrow = sub & full[DN_W];

endmodule

FILE: sv/gdo_core.sv
// Sequencer and datapath registers of the date offset unit: date check, day count, range check
// and month-by-month walk; the day count, range check and walk comparison share one gdo_alu.
// Depends on gdo_pkg and gdo_alu.
module gdo_core #(
    parameter int unsigned MAX_YEAR    = gdo_pkg::MAX_YEAR_DEF,
    parameter int unsigned OFFSET_BITS = gdo_pkg::OFFSET_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   mode,
    input  logic [4:0]             in_day,
    input  logic [3:0]             in_month,
    input  logic [13:0]            in_year,
    input  logic [OFFSET_BITS-1:0] offset_days,
    output logic                   busy,
    output gdo_pkg::result_t       result
);
    import gdo_pkg::*;

    localparam longint unsigned LIM_P = longint'(MAX_YEAR);
    localparam logic [DN_W-1:0] LIMIT_DAYS =
        DN_W'(LIM_P * 365 + LIM_P / 4 - LIM_P / 100 + LIM_P / 400);

    state_t state_reg, state_next;

    logic                   mode_reg, mode_next;
    logic [4:0]             d_reg, d_next;
    logic [3:0]             m_reg, m_next;
    logic [YEAR_W-1:0]      y_reg, y_next;
    logic [YEAR_W-1:0]      p_reg, p_next;
    logic [OFFSET_BITS-1:0] r_reg, r_next;
    logic [DN_W-1:0]        acc_reg, acc_next;
    logic [1:0]             k_reg, k_next;
    logic [8:0]             c400_reg, c400_next;
    logic [6:0]             c100_reg, c100_next;
    logic [1:0]             status_reg, status_next;

    logic [DN_W-1:0] alu_a;
    logic [DN_W-1:0] alu_b;
    logic            alu_sub;
    logic [DN_W-1:0] alu_res;
    logic            alu_borrow;

    logic            leap;
    logic [4:0]      mlen;
    logic            pre_bad;
    logic [5:0]      need;
    logic [8:0]      doy;
    logic [DN_W-1:0] r_ext;

    gdo_alu u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .sub    (alu_sub),
        .res    (alu_res),
        .borrow (alu_borrow)
    );

    assign leap    = is_leap(y_reg[1:0], c100_reg, c400_reg);
    assign mlen    = month_len(m_reg, leap);
    assign pre_bad = !(m_reg inside {[4'd1:4'd12]}) || (d_reg == 5'd0) || (y_reg == '0);
    assign need    = 6'(mlen) - 6'(d_reg) + 6'd1;
    assign doy     = CUM_DAYS[m_reg - 4'd1] + 9'(d_reg) - 9'd1
                     + 9'(leap && (m_reg > 4'd2));
    assign r_ext   = DN_W'(r_reg);
    assign busy    = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        d_reg      <= d_next;
        m_reg      <= m_next;
        y_reg      <= y_next;
        p_reg      <= p_next;
        r_reg      <= r_next;
        acc_reg    <= acc_next;
        k_reg      <= k_next;
        c400_reg   <= c400_next;
        c100_reg   <= c100_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                state_next = pre_bad ? S_FIN : S_DSUB;
            end
            S_DSUB:
            begin
                if (!alu_borrow)
                begin
                    state_next = S_DADD;
                end
                else if (k_reg == 2'd3)
                begin
                    state_next = S_CHECK;
                end
            end
            S_DADD:
            begin
                state_next = S_DSUB;
            end
            S_CHECK:
            begin
                state_next = (d_reg > mlen) ? S_FIN : S_DOY;
            end
            S_DOY:
            begin
                state_next = S_OFF;
            end
            S_OFF:
            begin
                state_next = (mode_reg && alu_borrow) ? S_FIN : S_LIM;
            end
            S_LIM:
            begin
                state_next = alu_borrow ? S_WALK : S_FIN;
            end
            S_WALK:
            begin
                if (alu_borrow)
                begin
                    state_next = S_FIN;
                end
                else if (mode_reg)
                begin
                    state_next = S_BFIX;
                end
            end
            S_BFIX:
            begin
                state_next = S_WALK;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mode_next   = mode_reg;
        d_next      = d_reg;
        m_next      = m_reg;
        y_next      = y_reg;
        p_next      = p_reg;
        r_next      = r_reg;
        acc_next    = acc_reg;
        k_next      = k_reg;
        c400_next   = c400_reg;
        c100_next   = c100_reg;
        status_next = status_reg;
        alu_a       = acc_reg;
        alu_b       = '0;
        alu_sub     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next   = mode;
                    d_next      = in_day;
                    m_next      = in_month;
                    y_next      = YEAR_W'(in_year);
                    r_next      = offset_days;
                    acc_next    = '0;
                    k_next      = 2'd0;
                    status_next = ST_OK;
                end
            end
            S_PRE:
            begin
                p_next = y_reg - YEAR_W'(1);
                if (pre_bad)
                begin
                    status_next = ST_BAD_DATE;
                end
            end
            S_DSUB:
            begin
                alu_a   = DN_W'(p_reg);
                alu_b   = DIV_YEARS[k_reg];
                alu_sub = 1'b1;
                if (!alu_borrow)
                begin
                    p_next = alu_res[YEAR_W-1:0];
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                    if (k_reg == 2'd0)
                    begin
                        c400_next = (p_reg[8:0] == 9'd399) ? 9'd0 : p_reg[8:0] + 9'd1;
                    end
                    if (k_reg == 2'd1)
                    begin
                        c100_next = (p_reg[6:0] == 7'd99) ? 7'd0 : p_reg[6:0] + 7'd1;
                    end
                end
            end
            S_DADD:
            begin
                alu_b    = DIV_DAYS[k_reg];
                acc_next = alu_res;
            end
            S_CHECK:
            begin
                if (d_reg > mlen)
                begin
                    status_next = ST_BAD_DATE;
                end
            end
            S_DOY:
            begin
                alu_b    = DN_W'(doy);
                acc_next = alu_res;
            end
            S_OFF:
            begin
                alu_b   = r_ext;
                alu_sub = mode_reg;
                if (mode_reg && alu_borrow)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    acc_next = alu_res;
                end
            end
            S_LIM:
            begin
                alu_b   = LIMIT_DAYS;
                alu_sub = 1'b1;
                if (!alu_borrow)
                begin
                    status_next = ST_RANGE;
                end
            end
            S_WALK:
            begin
                alu_a   = r_ext;
                alu_sub = 1'b1;
                if (!mode_reg)
                begin
                    alu_b = DN_W'(need);
                    if (alu_borrow)
                    begin
                        d_next = d_reg + r_ext[4:0];
                    end
                    else
                    begin
                        r_next = alu_res[OFFSET_BITS-1:0];
                        d_next = 5'd1;
                        if (m_reg == 4'd12)
                        begin
                            m_next    = 4'd1;
                            y_next    = y_reg + YEAR_W'(1);
                            c400_next = (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
                            c100_next = (c100_reg == 7'd99) ? 7'd0 : c100_reg + 7'd1;
                        end
                        else
                        begin
                            m_next = m_reg + 4'd1;
                        end
                    end
                end
                else
                begin
                    alu_b = DN_W'(d_reg);
                    if (alu_borrow)
                    begin
                        d_next = d_reg - r_ext[4:0];
                    end
                    else
                    begin
                        r_next = alu_res[OFFSET_BITS-1:0];
                        if (m_reg == 4'd1)
                        begin
                            m_next    = 4'd12;
                            y_next    = y_reg - YEAR_W'(1);
                            c400_next = (c400_reg == 9'd0) ? 9'd399 : c400_reg - 9'd1;
                            c100_next = (c100_reg == 7'd0) ? 7'd99 : c100_reg - 7'd1;
                        end
                        else
                        begin
                            m_next = m_reg - 4'd1;
                        end
                    end
                end
            end
            S_BFIX:
            begin
                d_next = mlen;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.valid  = (state_reg == S_FIN);
        result.status = status_reg;
        result.day    = d_reg;
        result.month  = m_reg;
        result.year   = y_reg;
        result.dn     = acc_reg;
    end

endmodule

FILE: sv/gdo_checker.sv
// Port-level checker for the Gregorian date offset unit, bound to the top level.
// Depends on gdo_pkg for status codes and on gregorian_date_offset_unit for the bind target.
module gdo_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [4:0]  out_day,
    input logic [3:0]  out_month,
    input logic [13:0] out_year,
    input logic [21:0] day_number,
    input logic [2:0]  weekday,
    input logic [1:0]  status
);
    import gdo_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done shown while still busy");

    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result");

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (out_day == 5'd1 && out_month == 4'd1 &&
            out_year == 14'd1 && day_number == 22'd0 && weekday == 3'd1))
        else $error("error result carries wrong fields");

    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_OK)) |-> (weekday != 3'd0 && out_day != 5'd0 &&
            out_month != 4'd0 && out_month <= 4'd12))
        else $error("ok result out of field range");

endmodule

bind gregorian_date_offset_unit gdo_checker u_gdo_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .out_day    (out_day),
    .out_month  (out_month),
    .out_year   (out_year),
    .day_number (day_number),
    .weekday    (weekday),
    .status     (status)
);
